@@ rtl/core/crd_pkg.sv @@
`default_nettype none

package crd_pkg;

    localparam int IMAGE_WIDTH_DEF  = 1024;
    localparam int IMAGE_HEIGHT_DEF = 768;

    // register stages through crd_norm
    localparam int NORM_LAT = 69;

    typedef enum logic [2:0] {
        REG_DIR_X        = 3'd0,
        REG_DIR_Y        = 3'd1,
        REG_DIR_Z        = 3'd2,
        REG_ORIGIN_X     = 3'd3,
        REG_ORIGIN_Y     = 3'd4,
        REG_ORIGIN_Z     = 3'd5,
        REG_TAN_HALF_FOV = 3'd6
    } cfg_reg_t;

    // three signed Q1.30 components, index 0 is x
    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        vec3_t t;
        vec3_t b;
        vec3_t v;
    } basis_t;

endpackage

`default_nettype wire

@@ rtl/core/crd_ifs.sv @@
`default_nettype none

interface crd_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface crd_ray_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ray_x;
    logic signed [31:0] ray_y;
    logic signed [31:0] ray_z;
    logic               degenerate;

    modport source (output valid, output ray_x, output ray_y, output ray_z,
                    output degenerate, input ready);
    modport sink   (input valid, input ray_x, input ray_y, input ray_z,
                    input degenerate, output ready);
endinterface

interface crd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/crd_scale.sv @@
`default_nettype none

module crd_scale #(
    parameter int MW = 63
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire logic [2:0][MW-1:0]   in_mag,
    input  wire logic [2:0]           in_neg,
    output logic                      out_vld,
    output logic [2:0][29:0]          out_mag,
    output logic [2:0]                out_neg,
    output logic                      out_zero
);

    localparam int PW = $clog2(MW);

    function automatic logic [PW-1:0] lead_one(input logic [MW-1:0] x);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (x[i])
            begin
                p = PW'(i);
            end
        end
        return p;
    endfunction

    logic                s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [2:0][MW-1:0]  s1_mag_reg, s2_mag_reg;
    logic [2:0]          s1_neg_reg, s2_neg_reg, s3_neg_reg;
    logic [MW-1:0]       s1_mx_reg;
    logic [PW-1:0]       s2_pos_reg;
    logic                s2_zero_reg, s3_zero_reg;
    logic [2:0][29:0]    s3_mag_reg;

    logic [MW-1:0]       mx01, mx_next;
    logic [PW-1:0]       rs, ls;
    logic [2:0][29:0]    sh_next;

    assign mx01    = (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
    assign mx_next = (mx01 > in_mag[2]) ? mx01 : in_mag[2];

    assign rs = s2_pos_reg - PW'(29);
    assign ls = PW'(29) - s2_pos_reg;

    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            if (s2_zero_reg)
            begin
                sh_next[q] = '0;
            end
            else if (s2_pos_reg >= PW'(29))
            begin
                sh_next[q] = 30'(s2_mag_reg[q] >> rs);
            end
            else
            begin
                sh_next[q] = 30'(s2_mag_reg[q] << ls);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg  <= in_mag;
            s1_neg_reg  <= in_neg;
            s1_mx_reg   <= mx_next;
            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_pos_reg  <= lead_one(s1_mx_reg);
            s2_zero_reg <= (s1_mx_reg == '0);
            s3_mag_reg  <= sh_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_zero_reg <= s2_zero_reg;
        end
    end

    assign out_vld  = s3_vld_reg;
    assign out_mag  = s3_mag_reg;
    assign out_neg  = s3_neg_reg;
    assign out_zero = s3_zero_reg;

endmodule

`default_nettype wire

@@ rtl/core/crd_norm.sv @@
`default_nettype none

module crd_norm #(
    parameter int MW = 63
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_vld,
    input  wire logic [2:0][MW-1:0]  in_mag,
    input  wire logic [2:0]          in_neg,
    output logic                     out_vld,
    output crd_pkg::vec3_t           out_vec
);

    import crd_pkg::*;

    localparam int SQ_N = 31;
    localparam int DV_N = 31;

    logic             sc_vld;
    logic [2:0][29:0] sc_mag;
    logic [2:0]       sc_neg;
    logic             sc_zero;

    crd_scale #(.MW(MW)) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_vld),
        .in_mag   (in_mag),
        .in_neg   (in_neg),
        .out_vld  (sc_vld),
        .out_mag  (sc_mag),
        .out_neg  (sc_neg),
        .out_zero (sc_zero)
    );

    // squares
    logic             sq_vld_reg;
    logic [2:0][59:0] sq_sq_reg;
    logic [2:0][29:0] sq_mag_reg;
    logic [2:0]       sq_neg_reg;
    logic             sq_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg <= sc_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int q = 0; q < 3; q++)
            begin
                sq_sq_reg[q] <= 60'(sc_mag[q]) * 60'(sc_mag[q]);
            end
            sq_mag_reg  <= sc_mag;
            sq_neg_reg  <= sc_neg;
            sq_zero_reg <= sc_zero;
        end
    end

    // square root, one result bit per stage; stage 0 holds the sum
    logic             sr_vld_reg  [0:SQ_N];
    logic [61:0]      sr_rem_reg  [0:SQ_N];
    logic [30:0]      sr_root_reg [0:SQ_N];
    logic [2:0][29:0] sr_mag_reg  [0:SQ_N];
    logic [2:0]       sr_neg_reg  [0:SQ_N];
    logic             sr_zero_reg [0:SQ_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sr_vld_reg[0] <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_rem_reg[0]  <= 62'(sq_sq_reg[0]) + 62'(sq_sq_reg[1]) + 62'(sq_sq_reg[2]);
            sr_root_reg[0] <= '0;
            sr_mag_reg[0]  <= sq_mag_reg;
            sr_neg_reg[0]  <= sq_neg_reg;
            sr_zero_reg[0] <= sq_zero_reg;
        end
    end

    for (genvar s = 0; s < SQ_N; s++)
    begin : g_sqrt
        localparam int K = SQ_N - 1 - s;
        logic [63:0] trial;
        logic [63:0] rem_w;

        assign trial = ({33'd0, sr_root_reg[s]} << (K + 1)) | (64'd1 << (2 * K));
        assign rem_w = {2'd0, sr_rem_reg[s]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sr_vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                sr_vld_reg[s+1] <= sr_vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_w >= trial)
                begin
                    sr_rem_reg[s+1]  <= 62'(rem_w - trial);
                    sr_root_reg[s+1] <= sr_root_reg[s] | (31'd1 << K);
                end
                else
                begin
                    sr_rem_reg[s+1]  <= sr_rem_reg[s];
                    sr_root_reg[s+1] <= sr_root_reg[s];
                end
                sr_mag_reg[s+1]  <= sr_mag_reg[s];
                sr_neg_reg[s+1]  <= sr_neg_reg[s];
                sr_zero_reg[s+1] <= sr_zero_reg[s];
            end
        end
    end

    // rounded division, one quotient bit per stage; stage 0 holds the dividend
    logic             dv_vld_reg  [0:DV_N];
    logic [2:0][60:0] dv_rem_reg  [0:DV_N];
    logic [2:0][30:0] dv_q_reg    [0:DV_N];
    logic [30:0]      dv_n_reg    [0:DV_N];
    logic [2:0]       dv_neg_reg  [0:DV_N];
    logic             dv_zero_reg [0:DV_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= sr_vld_reg[SQ_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int q = 0; q < 3; q++)
            begin
                dv_rem_reg[0][q] <= {1'b0, sr_mag_reg[SQ_N][q], 30'd0}
                                  + {31'd0, sr_root_reg[SQ_N][30:1]};
            end
            dv_q_reg[0]    <= '0;
            dv_n_reg[0]    <= sr_root_reg[SQ_N];
            dv_neg_reg[0]  <= sr_neg_reg[SQ_N];
            dv_zero_reg[0] <= sr_zero_reg[SQ_N];
        end
    end

    for (genvar s = 0; s < DV_N; s++)
    begin : g_div
        localparam int K = DV_N - 1 - s;
        logic [60:0] dsh;

        assign dsh = {30'd0, dv_n_reg[s]} << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[s+1] <= dv_vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int q = 0; q < 3; q++)
                begin
                    if (dv_rem_reg[s][q] >= dsh)
                    begin
                        dv_rem_reg[s+1][q] <= dv_rem_reg[s][q] - dsh;
                        dv_q_reg[s+1][q]   <= dv_q_reg[s][q] | (31'd1 << K);
                    end
                    else
                    begin
                        dv_rem_reg[s+1][q] <= dv_rem_reg[s][q];
                        dv_q_reg[s+1][q]   <= dv_q_reg[s][q];
                    end
                end
                dv_n_reg[s+1]    <= dv_n_reg[s];
                dv_neg_reg[s+1]  <= dv_neg_reg[s];
                dv_zero_reg[s+1] <= dv_zero_reg[s];
            end
        end
    end

    // sign and output
    logic  out_vld_reg;
    vec3_t out_vec_reg;
    vec3_t out_vec_next;

    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            if (dv_zero_reg[DV_N])
            begin
                out_vec_next[q] = '0;
            end
            else if (dv_neg_reg[DV_N][q])
            begin
                out_vec_next[q] = 32'd0 - {1'b0, dv_q_reg[DV_N][q]};
            end
            else
            begin
                out_vec_next[q] = {1'b0, dv_q_reg[DV_N][q]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld_reg[DV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_vec_reg <= out_vec_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign out_vec = out_vec_reg;

endmodule

`default_nettype wire

@@ rtl/core/crd_basis.sv @@
`default_nettype none

module crd_basis (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               restart,
    input  wire logic signed [31:0] dir_x,
    input  wire logic signed [31:0] dir_y,
    input  wire logic signed [31:0] dir_z,
    output logic                    busy,
    output crd_pkg::basis_t         basis
);

    import crd_pkg::*;

    localparam int CNT_W = $clog2(NORM_LAT + 2);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_RUN   = 4'b0010,
        B_MUL   = 4'b0100,
        B_CROSS = 4'b1000
    } bstate_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic [31:0] round30(input logic signed [63:0] p);
        logic [63:0] m;
        logic [63:0] r;
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + (64'd1 << 29)) >> 30;
        return p[63] ? 32'(64'd0 - r) : 32'(r);
    endfunction

    bstate_t            state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    vec3_t              t_reg, b_reg, v_reg;
    logic signed [63:0] pr_reg [6];

    logic [2:0][31:0]   nin_mag;
    logic [2:0]         nin_neg;
    logic               nin_vld;
    logic               nout_vld;
    vec3_t              nout_vec;

    assign nin_vld = (state_reg == B_RUN) && (cnt_reg < CNT_W'(2));

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            nin_mag[0] = mag32(dir_x);
            nin_neg[0] = dir_x[31];
            nin_mag[1] = mag32(dir_y);
            nin_neg[1] = dir_y[31];
            nin_mag[2] = mag32(dir_z);
            nin_neg[2] = dir_z[31];
        end
        else
        begin
            // right vector before normalization: (dz, 0, -dx)
            nin_mag[0] = mag32(dir_z);
            nin_neg[0] = dir_z[31];
            nin_mag[1] = '0;
            nin_neg[1] = 1'b0;
            nin_mag[2] = mag32(dir_x);
            nin_neg[2] = !dir_x[31] && (dir_x != '0);
        end
    end

    crd_norm #(.MW(32)) u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (1'b1),
        .in_vld  (nin_vld),
        .in_mag  (nin_mag),
        .in_neg  (nin_neg),
        .out_vld (nout_vld),
        .out_vec (nout_vec)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                state_next = B_IDLE;
            end
            B_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NORM_LAT + 1))
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_CROSS;
            end
            B_CROSS:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_RUN;
                cnt_next   = '0;
            end
        endcase
        if (restart)
        begin
            state_next = B_RUN;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_RUN;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_RUN && nout_vld && cnt_reg == CNT_W'(NORM_LAT))
        begin
            t_reg <= nout_vec;
        end
        if (state_reg == B_RUN && nout_vld && cnt_reg == CNT_W'(NORM_LAT + 1))
        begin
            b_reg <= nout_vec;
        end
        if (state_reg == B_MUL)
        begin
            pr_reg[0] <= $signed(t_reg[1]) * $signed(b_reg[2]);
            pr_reg[1] <= $signed(t_reg[2]) * $signed(b_reg[1]);
            pr_reg[2] <= $signed(t_reg[2]) * $signed(b_reg[0]);
            pr_reg[3] <= $signed(t_reg[0]) * $signed(b_reg[2]);
            pr_reg[4] <= $signed(t_reg[0]) * $signed(b_reg[1]);
            pr_reg[5] <= $signed(t_reg[1]) * $signed(b_reg[0]);
        end
        if (state_reg == B_CROSS)
        begin
            v_reg[0] <= round30(pr_reg[0] - pr_reg[1]);
            v_reg[1] <= round30(pr_reg[2] - pr_reg[3]);
            v_reg[2] <= round30(pr_reg[4] - pr_reg[5]);
        end
    end

    assign busy    = (state_reg != B_IDLE);
    assign basis.t = t_reg;
    assign basis.b = b_reg;
    assign basis.v = v_reg;

endmodule

`default_nettype wire

@@ rtl/core/crd_ray.sv @@
`default_nettype none

module crd_ray #(
    parameter int IMAGE_WIDTH  = crd_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = crd_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_vld,
    input  wire logic [11:0] pixel_col,
    input  wire logic [11:0] pixel_row,
    input  wire logic [23:0] tan_half_fov,
    input  crd_pkg::basis_t  basis,
    output logic             out_vld,
    output crd_pkg::vec3_t   out_vec
);

    import crd_pkg::*;

    localparam logic [24:0] WM1SQ = 25'((IMAGE_WIDTH - 1) * (IMAGE_WIDTH - 1));
    localparam logic [24:0] HM1SQ = 25'((IMAGE_HEIGHT - 1) * (IMAGE_HEIGHT - 1));
    localparam logic [62:0] COEF0 = 63'(64'(WM1SQ) * 64'(IMAGE_HEIGHT - 1) * 64'd65536);

    function automatic logic [62:0] mag63(input logic signed [63:0] x);
        return x[63] ? 63'(-x) : 63'(x);
    endfunction

    // pixel offsets
    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic signed [14:0] s1_a_reg, s1_c_reg;
    logic signed [40:0] s2_a_reg, s2_c_reg;
    logic signed [63:0] s3_a_reg, s3_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg <= $signed({2'b00, pixel_col, 1'b0}) - 15'(IMAGE_WIDTH + 1);
            s1_c_reg <= 15'(IMAGE_HEIGHT + 1) - $signed({2'b00, pixel_row, 1'b0});
            s2_a_reg <= s1_a_reg * $signed({1'b0, HM1SQ});
            s2_c_reg <= s1_c_reg * $signed({1'b0, WM1SQ});
            s3_a_reg <= s2_a_reg * $signed({1'b0, tan_half_fov});
            s3_c_reg <= s2_c_reg * $signed({1'b0, tan_half_fov});
        end
    end

    // coefficient scaling
    logic [2:0][62:0] k_in_mag;
    logic [2:0]       k_in_neg;
    logic             k_vld;
    logic [2:0][29:0] k_mag;
    logic [2:0]       k_neg;

    assign k_in_mag[0] = COEF0;
    assign k_in_neg[0] = 1'b0;
    assign k_in_mag[1] = mag63(s3_a_reg);
    assign k_in_neg[1] = s3_a_reg[63];
    assign k_in_mag[2] = mag63(s3_c_reg);
    assign k_in_neg[2] = s3_c_reg[63];

    crd_scale #(.MW(63)) u_kscale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s3_vld_reg),
        .in_mag   (k_in_mag),
        .in_neg   (k_in_neg),
        .out_vld  (k_vld),
        .out_mag  (k_mag),
        .out_neg  (k_neg),
        .out_zero ()
    );

    // R = k0*t + k1*b + k2*v
    logic signed [30:0] ks [3];
    vec3_t              term [3];

    assign term[0] = basis.t;
    assign term[1] = basis.b;
    assign term[2] = basis.v;

    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            ks[p] = k_neg[p] ? $signed(31'd0 - {1'b0, k_mag[p]}) : $signed({1'b0, k_mag[p]});
        end
    end

    logic               r1_vld_reg, r2_vld_reg;
    logic signed [62:0] r1_reg [3][3];
    logic signed [63:0] r2_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_vld_reg <= k_vld;
            r2_vld_reg <= r1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int q = 0; q < 3; q++)
            begin
                for (int p = 0; p < 3; p++)
                begin
                    r1_reg[q][p] <= ks[p] * $signed(term[p][q]);
                end
                r2_reg[q] <= 64'(r1_reg[q][0]) + 64'(r1_reg[q][1]) + 64'(r1_reg[q][2]);
            end
        end
    end

    logic [2:0][62:0] r_mag;
    logic [2:0]       r_neg;

    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            r_mag[q] = mag63(r2_reg[q]);
            r_neg[q] = r2_reg[q][63];
        end
    end

    crd_norm #(.MW(63)) u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (r2_vld_reg),
        .in_mag  (r_mag),
        .in_neg  (r_neg),
        .out_vld (out_vld),
        .out_vec (out_vec)
    );

endmodule

`default_nettype wire

@@ rtl/core/camera_ray_direction.sv @@
`default_nettype none
// Throughput: one item per cycle; the pipeline holds while a ray item waits.
// Reset (rst_n, async, active low) clears control state and sets the camera registers.
// After reset and after each view direction write, a basis pass (two
// normalizations through one shared unit, then the cross product) holds pixel ready low.

module camera_ray_direction #(
    parameter int IMAGE_WIDTH  = crd_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = crd_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    crd_pix_if.sink   pix,
    crd_ray_if.source ray,
    crd_cfg_if.sink   cfg
);

    import crd_pkg::*;

    logic signed [31:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [23:0]        tan_reg;
    logic               cfg_wr;
    logic               restart;
    logic               busy;
    logic               deg;
    logic               en;
    logic               nv_vld;
    vec3_t              nv_vec;
    basis_t             basis;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign restart   = cfg_wr && ((cfg.index == REG_DIR_X) || (cfg.index == REG_DIR_Y)
                                  || (cfg.index == REG_DIR_Z));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= 32'sd65536;
            tan_reg   <= 24'd65536;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                REG_DIR_X:        dir_x_reg <= cfg.data;
                REG_DIR_Y:        dir_y_reg <= cfg.data;
                REG_DIR_Z:        dir_z_reg <= cfg.data;
                REG_TAN_HALF_FOV: tan_reg   <= cfg.data[23:0];
                REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    crd_basis u_basis (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .dir_x   (dir_x_reg),
        .dir_y   (dir_y_reg),
        .dir_z   (dir_z_reg),
        .busy    (busy),
        .basis   (basis)
    );

    assign en        = !nv_vld || ray.ready;
    assign pix.ready = en && !busy;

    crd_ray #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_ray (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (pix.valid && pix.ready),
        .pixel_col    (pix.pixel_col),
        .pixel_row    (pix.pixel_row),
        .tan_half_fov (tan_reg),
        .basis        (basis),
        .out_vld      (nv_vld),
        .out_vec      (nv_vec)
    );

    // zero or vertical view direction
    assign deg = (dir_x_reg == '0) && (dir_z_reg == '0);

    assign ray.valid      = nv_vld;
    assign ray.ray_x      = deg ? '0 : $signed(nv_vec[0]);
    assign ray.ray_y      = deg ? '0 : $signed(nv_vec[1]);
    assign ray.ray_z      = deg ? '0 : $signed(nv_vec[2]);
    assign ray.degenerate = deg;

endmodule

`default_nettype wire

@@ sim/tb_camera_ray_direction.sv @@
`timescale 1ns / 1ps

module tb_camera_ray_direction;
    import crd_pkg::*;

    localparam int W = IMAGE_WIDTH_DEF;
    localparam int H = IMAGE_HEIGHT_DEF;
    localparam longint LIMIT = 2000000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               degen;
    } ray_t;

    logic clk;
    logic rst_n;

    crd_pix_if pix();
    crd_ray_if ray();
    crd_cfg_if cfg();

    camera_ray_direction dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix.sink),
        .ray   (ray.source),
        .cfg   (cfg.sink)
    );

    longint dir_x, dir_y, dir_z, org_x, org_y, org_z, tan_fov;
    ray_t   ray_q[$];
    int     errors;
    longint cycle;
    bit     stall_on;
    bit     ray_took;
    int     ready_wait;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint sgn(longint m, bit n);
        return n ? -m : m;
    endfunction

    task automatic scale_vec(input longint w[3], output longint m[3], output bit n[3]);
        longint mx;
        mx = 0;
        for (int q = 0; q < 3; q++)
        begin
            n[q] = w[q] < 0;
            m[q] = mag(w[q]);
            if (m[q] > mx)
                mx = m[q];
        end
        if (mx != 0)
        begin
            while (mx >= (64'sd1 <<< 30))
            begin
                mx = mx >>> 1;
                for (int q = 0; q < 3; q++)
                    m[q] = m[q] >>> 1;
            end
            while (mx < (64'sd1 <<< 29))
            begin
                mx = mx <<< 1;
                for (int q = 0; q < 3; q++)
                    m[q] = m[q] <<< 1;
            end
        end
    endtask

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic unit_vec(input longint w[3], output longint o[3]);
        longint      m[3];
        bit          n[3];
        logic [63:0] sum, nr;
        scale_vec(w, m, n);
        sum = 0;
        for (int q = 0; q < 3; q++)
            sum = sum + m[q] * m[q];
        nr = int_sqrt(sum);
        for (int q = 0; q < 3; q++)
            o[q] = (nr == 0) ? 0 : sgn(((m[q] << 30) + nr / 2) / nr, n[q]);
    endtask

    function automatic longint round_q30(longint p);
        return sgn((mag(p) + (64'sd1 <<< 29)) >>> 30, p < 0);
    endfunction

    task automatic predict_ray(input int col, input int row, output ray_t r);
        longint d[3], hv[3], t[3], b[3], v[3], cf[3], k[3], rr[3], o[3];
        longint km[3];
        bit     kn[3];
        longint wm1, hm1;
        wm1 = W - 1;
        hm1 = H - 1;
        if (dir_x == 0 && dir_z == 0)
        begin
            r = '{0, 0, 0, 1'b1};
            return;
        end
        d = '{dir_x, dir_y, dir_z};
        unit_vec(d, t);
        hv = '{dir_z, 0, -dir_x};
        unit_vec(hv, b);
        v[0] = round_q30(t[1] * b[2] - t[2] * b[1]);
        v[1] = round_q30(t[2] * b[0] - t[0] * b[2]);
        v[2] = round_q30(t[0] * b[1] - t[1] * b[0]);
        cf[0] = wm1 * wm1 * hm1 * 65536;
        cf[1] = tan_fov * hm1 * hm1 * (2 * col - W - 1);
        cf[2] = tan_fov * wm1 * wm1 * (H - 2 * row + 1);
        scale_vec(cf, km, kn);
        for (int q = 0; q < 3; q++)
            k[q] = sgn(km[q], kn[q]);
        for (int q = 0; q < 3; q++)
            rr[q] = k[0] * t[q] + k[1] * b[q] + k[2] * v[q];
        unit_vec(rr, o);
        r.x = o[0][31:0];
        r.y = o[1][31:0];
        r.z = o[2][31:0];
        r.degen = 1'b0;
    endtask

    task automatic send_pixel(input int col, input int row);
        ray_t e;
        int   gap;
        gap = $urandom_range(0, 9);
        if (gap != 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel_col <= col[11:0];
        pix.pixel_row <= row[11:0];
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        predict_ray(col, row, e);
        ray_q.push_back(e);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        pix.valid <= 1'b0;
        while (ray_q.size() != 0)
            @(negedge clk);
        repeat (90)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_DIR_X:        dir_x = longint'(signed'(val));
            REG_DIR_Y:        dir_y = longint'(signed'(val));
            REG_DIR_Z:        dir_z = longint'(signed'(val));
            REG_ORIGIN_X:     org_x = longint'(signed'(val));
            REG_ORIGIN_Y:     org_y = longint'(signed'(val));
            REG_ORIGIN_Z:     org_z = longint'(signed'(val));
            REG_TAN_HALF_FOV: tan_fov = val[23:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_camera(input logic [31:0] dx, input logic [31:0] dy,
                              input logic [31:0] dz, input logic [23:0] tf);
        wait_drain();
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_TAN_HALF_FOV, {8'd0, tf});
    endtask

    // ray output: random backpressure per item, with stall-free stretches
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            ray.ready <= 1'b0;
            ready_wait = 0;
        end
        else
        begin
            if (ray_took)
            begin
                ray_took = 1'b0;
                ready_wait = stall_on ? $urandom_range(0, 9) : 0;
            end
            if (ready_wait > 0)
            begin
                ray.ready <= 1'b0;
                ready_wait--;
            end
            else
                ray.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        ray_t e;
        if (rst_n && ray.valid && ray.ready)
        begin
            ray_took = 1'b1;
            if (ray_q.size() == 0)
            begin
                $display("%0t unexpected ray item", $time);
                errors++;
            end
            else
            begin
                e = ray_q.pop_front();
                if (ray.ray_x !== e.x || ray.ray_y !== e.y || ray.ray_z !== e.z
                    || ray.degenerate !== e.degen)
                begin
                    $display("%0t mismatch exp %0d %0d %0d %b got %0d %0d %0d %b",
                             $time, e.x, e.y, e.z, e.degen, ray.ray_x, ray.ray_y,
                             ray.ray_z, ray.degenerate);
                    errors++;
                end
            end
        end
    end

    task automatic test_reset_camera();
        send_pixel(1, 1);
        send_pixel(W / 2, H / 2);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(W, H);
    endtask

    task automatic test_origin();
        wait_drain();
        write_reg(REG_ORIGIN_X, 32'h7fff_ffff);
        write_reg(REG_ORIGIN_Y, 32'h8000_0000);
        write_reg(REG_ORIGIN_Z, $urandom);
        send_pixel(3, 700);
    endtask

    task automatic test_corner_cameras();
        set_camera(32'd0, 32'd65536, 32'd0, 24'd65536);
        send_pixel(10, 10);
        send_pixel(4095, 0);
        set_camera(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff);
        send_pixel(0, 4095);
        send_pixel(4095, 4095);
        set_camera(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 24'd0);
        send_pixel(0, 0);
        send_pixel(1234, 567);
        set_camera(32'd1, 32'd0, 32'hffff_ffff, 24'd1);
        send_pixel(1, 768);
        send_pixel(1024, 1);
        set_camera(32'd0, 32'd0, 32'hffff_0000, 24'd30000);
        send_pixel(512, 384);
        send_pixel(2048, 3000);
        set_camera(32'd0, 32'd0, 32'd0, 24'd65536);
        send_pixel(5, 5);
    endtask

    task automatic test_random();
        logic [31:0] dx, dz;
        for (int p = 0; p < 12; p++)
        begin
            dx = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom >>> $urandom_range(0, 16);
            dz = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom >>> $urandom_range(0, 16);
            if ($urandom_range(0, 9) == 0)
            begin
                dx = 0;
                dz = 0;
            end
            set_camera(dx, $urandom, dz, 24'($urandom));
            stall_on = (p % 3) != 0;
            for (int n = 0; n < 150; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                else
                    send_pixel($urandom_range(1, W), $urandom_range(1, H));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cycle = 0;
        errors = 0;
        stall_on = 1'b1;
        ray_took = 1'b0;
        ready_wait = 0;
        pix.valid = 1'b0;
        pix.pixel_col = '0;
        pix.pixel_row = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_DIR_X;
        cfg.data = '0;
        ray.ready = 1'b0;
        dir_x = 0; dir_y = 0; dir_z = 65536;
        org_x = 0; org_y = 0; org_z = 0;
        tan_fov = 65536;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        test_reset_camera();
        test_origin();
        test_corner_cameras();
        test_random();
        wait_drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
